/* design/rgbup_pkg.sv */
// Shared types, constants and helper functions for the RGBA to RGB565 upscaler.
// Has no dependencies; every other file in the design imports it.
`timescale 1ns / 1ps

package rgbup_pkg;

    // Framebuffer geometry.
    localparam int SCREEN_W = 320;
    localparam int SCREEN_H = 240;

    // Counter and address widths.
    localparam int COL_W  = $clog2(SCREEN_W);
    localparam int ROW_W  = $clog2(SCREEN_H);
    localparam int ADDR_W = 17;
    localparam int PIX_W  = 32;
    localparam int C565_W = 16;

    // Scale mode register codes.
    localparam logic [1:0] MODE_X1 = 2'd0;
    localparam logic [1:0] MODE_X2 = 2'd1;
    localparam logic [1:0] MODE_X4 = 2'd2;

    // Source frame sizes per factor; a size that would be zero is one.
    localparam int SRC_W_X1 = SCREEN_W;
    localparam int SRC_W_X2 = (SCREEN_W / 2 == 0) ? 1 : SCREEN_W / 2;
    localparam int SRC_W_X4 = (SCREEN_W / 4 == 0) ? 1 : SCREEN_W / 4;
    localparam int SRC_H_X1 = SCREEN_H;
    localparam int SRC_H_X2 = (SCREEN_H / 2 == 0) ? 1 : SCREEN_H / 2;
    localparam int SRC_H_X4 = (SCREEN_H / 4 == 0) ? 1 : SCREEN_H / 4;

    // Input transaction payload.
    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             first_of_frame;
    } in_t;

    // Output transaction payload.
    typedef struct packed {
        logic [ADDR_W-1:0] dest_addr;
        logic [C565_W-1:0] pixel_565;
        logic              last_of_block;
    } out_t;

    // One source pixel ready for expansion into a block of writes.
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [C565_W-1:0] color;
        logic [1:0]        shift;
    } blk_t;

    // Scale factor as a shift amount; the unused code acts as full resolution.
    function automatic logic [1:0] shift_of(input logic [1:0] mode);
        logic [1:0] s;
        begin
            unique case (mode)
                MODE_X2: s = 2'd1;
                MODE_X4: s = 2'd2;
                default: s = 2'd0;
            endcase
            return s;
        end
    endfunction

    // Source frame width for a given shift.
    function automatic logic [COL_W:0] src_width(input logic [1:0] shift);
        logic [COL_W:0] w;
        begin
            unique case (shift)
                2'd1:    w = (COL_W+1)'(SRC_W_X2);
                2'd2:    w = (COL_W+1)'(SRC_W_X4);
                default: w = (COL_W+1)'(SRC_W_X1);
            endcase
            return w;
        end
    endfunction

    // Source frame height for a given shift.
    function automatic logic [ROW_W:0] src_height(input logic [1:0] shift);
        logic [ROW_W:0] h;
        begin
            unique case (shift)
                2'd1:    h = (ROW_W+1)'(SRC_H_X2);
                2'd2:    h = (ROW_W+1)'(SRC_H_X4);
                default: h = (ROW_W+1)'(SRC_H_X1);
            endcase
            return h;
        end
    endfunction

    // Highest in-block row or column index for a given shift.
    function automatic logic [1:0] last_idx(input logic [1:0] shift);
        logic [1:0] m;
        begin
            unique case (shift)
                2'd1:    m = 2'd1;
                2'd2:    m = 2'd3;
                default: m = 2'd0;
            endcase
            return m;
        end
    endfunction

    // Keep the top bits of each color channel and drop alpha.
    function automatic logic [C565_W-1:0] to_565(input logic [PIX_W-1:0] px);
        begin
            return {px[7:3], px[15:10], px[23:19]};
        end
    endfunction

endpackage

/* design/rgbup_position.sv */
// Source position tracker: holds the source column and row and forms the
// base framebuffer address of each accepted pixel. Depends on rgbup_pkg.
`timescale 1ns / 1ps

module rgbup_position
    import rgbup_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  in_t        item,
    input  logic [1:0] shift,
    output blk_t       blk
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic [COL_W:0]   sw;
    logic [ROW_W:0]   sh;
    logic [COL_W-1:0] col_a, col_b;
    logic [ROW_W-1:0] row_a, row_c;
    logic [ROW_W:0]   row_b;
    logic [COL_W:0]   col_n;
    logic [ROW_W:0]   row_n;
    logic [ROW_W+1:0] row_s;
    logic [COL_W+1:0] col_s;

    // Position used by this pixel, after the frame start and wrap rules.
    always_comb
    begin
        sw    = src_width(shift);
        sh    = src_height(shift);
        col_a = item.first_of_frame ? '0 : col_reg;
        row_a = item.first_of_frame ? '0 : row_reg;
        if ({1'b0, col_a} >= sw)
        begin
            col_b = '0;
            row_b = {1'b0, row_a} + 1'b1;
        end
        else
        begin
            col_b = col_a;
            row_b = {1'b0, row_a};
        end
        row_c = (row_b >= sh) ? '0 : row_b[ROW_W-1:0];
    end

    // Position of the next pixel.
    always_comb
    begin
        col_n = {1'b0, col_b} + 1'b1;
        row_n = {1'b0, row_c} + 1'b1;
        if (col_n >= sw)
        begin
            col_next = '0;
            row_next = (row_n >= sh) ? '0 : row_n[ROW_W-1:0];
        end
        else
        begin
            col_next = col_n[COL_W-1:0];
            row_next = row_c;
        end
    end

    // Top-left destination address of the block and the converted color.
    always_comb
    begin
        row_s      = {2'b00, row_c} << shift;
        col_s      = {2'b00, col_b} << shift;
        blk.base   = ADDR_W'(ADDR_W'(row_s) * ADDR_W'(SCREEN_W)) + ADDR_W'(col_s);
        blk.color  = to_565(item.pixel_in);
        blk.shift  = shift;
    end

    // Position counters advance once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* design/rgbup_expand.sv */
// Block expander: holds one source pixel and emits its factor x factor
// framebuffer writes through an output register. Depends on rgbup_pkg.
`timescale 1ns / 1ps

module rgbup_expand
    import rgbup_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  blk_t blk,
    output logic busy,
    output logic out_valid,
    input  logic out_stall,
    output out_t out_data
);

    logic       blk_valid_reg;
    blk_t       blk_reg;
    logic [1:0] dy_reg, dx_reg;
    logic       out_valid_reg;
    out_t       out_reg;

    logic [1:0]        fmax;
    logic              last;
    logic              out_ld;
    logic              emit;
    logic [ADDR_W-1:0] addr;

    // Current write of the block and the output register load condition.
    always_comb
    begin
        fmax   = last_idx(blk_reg.shift);
        last   = (dx_reg == fmax) && (dy_reg == fmax);
        out_ld = !out_valid_reg || !out_stall;
        emit   = blk_valid_reg && out_ld;
        addr   = blk_reg.base + ADDR_W'(ADDR_W'(dy_reg) * ADDR_W'(SCREEN_W))
                 + ADDR_W'(dx_reg);
    end

    // A new pixel may enter in the cycle its predecessor's last write leaves.
    assign busy = blk_valid_reg && !(emit && last);

    // Held pixel and its position inside the block.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            dy_reg        <= '0;
            dx_reg        <= '0;
        end
        else if (accept)
        begin
            blk_valid_reg <= 1'b1;
            dy_reg        <= '0;
            dx_reg        <= '0;
        end
        else if (emit)
        begin
            if (last)
            begin
                blk_valid_reg <= 1'b0;
            end
            else if (dx_reg == fmax)
            begin
                dx_reg <= '0;
                dy_reg <= dy_reg + 1'b1;
            end
            else
            begin
                dx_reg <= dx_reg + 1'b1;
            end
        end
    end

    // Payload of the held pixel needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg <= blk;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ld)
        begin
            out_valid_reg <= emit;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.dest_addr     <= addr;
            out_reg.pixel_565     <= blk_reg.color;
            out_reg.last_of_block <= last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* design/rgba_to_rgb565_integer_upscaler.sv */
// RGBA to RGB565 nearest-neighbor upscaler, top level with the mode register.
// Depends on rgbup_pkg, rgbup_position and rgbup_expand.
// Each input transaction is one 32-bit source pixel; it yields 1, 4 or 16
// output transactions (scale mode 0, 1 or 2; mode 3 acts as mode 0), one
// framebuffer write per cycle while the output is not stalled, in row-major
// order within the block, the last one flagged by last_of_block. The next
// pixel is accepted in the same cycle as the previous pixel's final write
// enters the output register, so without output stalls the block sustains
// one write per cycle. Writes leave through an output register. Write
// scale_mode only while no transaction is in flight.
`timescale 1ns / 1ps

module rgba_to_rgb565_integer_upscaler
    import rgbup_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    logic [1:0] scale_mode_reg;
    logic       busy;
    logic       accept;
    blk_t       blk;

    // Scale mode configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_mode_reg <= MODE_X1;
        end
        else if (cfg_we)
        begin
            scale_mode_reg <= cfg_wdata;
        end
    end

    // Input transaction handshake.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    rgbup_position u_position (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .item  (in_data),
        .shift (shift_of(scale_mode_reg)),
        .blk   (blk)
    );

    rgbup_expand u_expand (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .blk      (blk),
        .busy     (busy),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    // A taken write that is not the last of its block is followed at once
    // by another write of the same color.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last_of_block |=>
            out_valid && (out_data.pixel_565 == $past(out_data.pixel_565)))
        else $error("block write sequence broken");

    // While a non-last write is held up, the block still has writes to go.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !out_data.last_of_block |-> in_stall)
        else $error("new pixel accepted before block finished");

endmodule

/* test/rgbup_write_checker.sv */
// Checker for the RGBA to RGB565 upscaler: watches both channels and the mode register.
// Predicts the framebuffer writes of each source pixel and compares them in order.
// Depends on rgbup_pkg for the payload types, the mode codes and the screen size.
`timescale 1ns / 1ps

module rgbup_write_checker
    import rgbup_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  in_t        in_data,
    input  logic       out_valid,
    input  logic       out_stall,
    input  out_t       out_data,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    output int         fail_count,
    output int         pending
);

    // Model state: scale mode and the source position of the next pixel.
    logic [1:0]  mode_reg;
    int unsigned src_col;
    int unsigned src_row;

    // Framebuffer writes predicted but not yet seen, oldest first.
    out_t        write_q[$];

    // Expand one accepted source pixel into its block of framebuffer writes.
    task automatic expand_pixel(input in_t item);
        int unsigned factor;
        int unsigned width;
        int unsigned height;
        int unsigned dy;
        int unsigned dx;
        out_t        wr;
        begin
            case (mode_reg)
                MODE_X2: factor = 2;
                MODE_X4: factor = 4;
                default: factor = 1;
            endcase
            width  = SCREEN_W / factor;
            height = SCREEN_H / factor;
            if (width == 0)
                width = 1;
            if (height == 0)
                height = 1;

            // A frame start, or a position left out of range by a mode change.
            if (item.first_of_frame)
            begin
                src_col = 0;
                src_row = 0;
            end
            if (src_col >= width)
            begin
                src_col = 0;
                src_row = src_row + 1;
            end
            if (src_row >= height)
                src_row = 0;

            for (dy = 0; dy < factor; dy++)
            begin
                for (dx = 0; dx < factor; dx++)
                begin
                    wr.dest_addr = ADDR_W'((src_row * factor + dy) * SCREEN_W
                                           + src_col * factor + dx);
                    wr.pixel_565 = {item.pixel_in[7:3], item.pixel_in[15:10],
                                    item.pixel_in[23:19]};
                    wr.last_of_block = (dy == factor - 1) && (dx == factor - 1);
                    write_q.push_back(wr);
                end
            end

            // Advance in raster order and wrap at the end of the frame.
            src_col = src_col + 1;
            if (src_col >= width)
            begin
                src_col = 0;
                src_row = src_row + 1;
                if (src_row >= height)
                    src_row = 0;
            end
        end
    endtask

    // Track inputs and the register, then check every accepted output transaction.
    always @(posedge clk or negedge rst_n)
    begin : track
        out_t want;
        int   errs;
        if (!rst_n)
        begin
            write_q.delete();
            mode_reg   = MODE_X1;
            src_col    = 0;
            src_row    = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && !in_stall)
                expand_pixel(in_data);
            if (cfg_we)
                mode_reg = cfg_wdata;
            if (out_valid && !out_stall)
            begin
                if (write_q.size() == 0)
                begin
                    $error("unexpected write: dest_addr %0d, pixel_565 %h",
                           out_data.dest_addr, out_data.pixel_565);
                    errs = 1;
                end
                else
                begin
                    want = write_q.pop_front();
                    if (out_data.dest_addr !== want.dest_addr)
                    begin
                        $error("dest_addr: expected %0d, actual %0d",
                               want.dest_addr, out_data.dest_addr);
                        errs++;
                    end
                    if (out_data.pixel_565 !== want.pixel_565)
                    begin
                        $error("pixel_565: expected %h, actual %h",
                               want.pixel_565, out_data.pixel_565);
                        errs++;
                    end
                    if (out_data.last_of_block !== want.last_of_block)
                    begin
                        $error("last_of_block: expected %0b, actual %0b",
                               want.last_of_block, out_data.last_of_block);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= write_q.size();
        end
    end

endmodule

/* test/tb.sv */
// Testbench top for the RGBA to RGB565 upscaler: clock, reset, stimulus and verdict.
// Depends on rgbup_pkg, the design files and rgbup_write_checker.
`timescale 1ns / 1ps

module tb;
    import rgbup_pkg::*;

    localparam int STUCK_LIMIT = 2000;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_t        in_data;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       calm = 1'b0;
    int         fail_count;
    int         pending;
    int         stuck_cycles = 0;

    always #5 clk = ~clk;

    rgba_to_rgb565_integer_upscaler u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    rgbup_write_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // The framebuffer side stalls at random, except during a calm stretch.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end

    // Watchdog: end the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one source pixel, with random idle cycles ahead of it.
    task automatic push_pixel(input logic [31:0] px, input logic fof);
        in_t item;
        begin
            item.pixel_in       = px;
            item.first_of_frame = fof;
            @(negedge clk);
            while (!calm && ($urandom_range(0, 99) < 26))
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= item;
            do
                @(posedge clk);
            while (in_stall);
        end
    endtask

    // Stop sending and wait until every predicted write has come out.
    task automatic wait_writes_done();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (pending != 0)
                @(posedge clk);
        end
    endtask

    // Write the scale mode register; called only while the block is idle.
    task automatic write_scale_mode(input logic [1:0] mode);
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= mode;
            @(negedge clk);
            cfg_we    <= 1'b0;
        end
    endtask

    // Send a run of random pixels that do not start a new frame.
    task automatic push_run(input int count);
        begin
            repeat (count)
                push_pixel($urandom, 1'b0);
        end
    endtask

    initial
    begin
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = MODE_X1;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: color channel extremes at full resolution.
        write_scale_mode(MODE_X1);
        push_pixel(32'h0000_0000, 1'b1);
        push_pixel(32'hFFFF_FFFF, 1'b0);
        push_pixel(32'h0000_00FF, 1'b0);
        push_pixel(32'h0000_FF00, 1'b0);
        push_pixel(32'h00FF_0000, 1'b0);
        push_pixel(32'hFF00_0000, 1'b0);
        push_pixel(32'h0007_0307, 1'b0);

        // Doubling, with a frame restart in the middle.
        wait_writes_done();
        write_scale_mode(MODE_X2);
        push_pixel(32'h1234_5678, 1'b0);
        push_pixel(32'hAAAA_AAAA, 1'b0);
        push_pixel(32'h5555_5555, 1'b1);

        // Quadrupling.
        wait_writes_done();
        write_scale_mode(MODE_X4);
        push_pixel(32'hFFFF_FFFF, 1'b1);
        push_pixel(32'h0000_0000, 1'b0);
        push_pixel(32'h00F8_FCF8, 1'b0);

        // The unused mode code behaves as full resolution.
        wait_writes_done();
        write_scale_mode(2'd3);
        push_pixel($urandom, 1'b0);
        push_pixel($urandom, 1'b1);

        // Column past the new width after a mode change: doubling to x4.
        wait_writes_done();
        write_scale_mode(MODE_X2);
        push_pixel($urandom, 1'b1);
        push_run(84);
        wait_writes_done();
        write_scale_mode(MODE_X4);
        push_run(3);

        // Random phases, each under a random mode; one runs without idling.
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_writes_done();
            write_scale_mode(2'($urandom_range(0, 3)));
            calm = (phase == 2);
            for (int k = 0; k < 27; k++)
            begin
                push_pixel($urandom, $urandom_range(0, 19) == 0);
                if ($urandom_range(0, 29) == 0)
                    wait_writes_done();
            end
        end
        calm = 1'b0;

        // Let the last writes drain, then keep watching for stray writes.
        wait_writes_done();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* filelist.f */
design/rgbup_pkg.sv
design/rgbup_position.sv
design/rgbup_expand.sv
design/rgba_to_rgb565_integer_upscaler.sv
test/rgbup_write_checker.sv
test/tb.sv
